>>> src/acsp_pkg.sv
`default_nettype none
package acsp_pkg;

  localparam int DEF_MAX_SIDE   = 1024;
  localparam int DEF_MAX_BLOCKS = 64;

  localparam int CNT_W   = 11;
  localparam int TOTAL_W = 21;
  localparam int ACC_W   = TOTAL_W + 1;
  localparam int BLK_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CNT_W-1:0]   SLICE_CNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_AXIS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_WIDTH = 3'd4;

  typedef struct packed {
    logic slice_axis;
    logic [BLK_W-1:0] block_count;
    logic [CNT_W-1:0] grid_width;
    logic [CNT_W-1:0] grid_height;
    logic [7:0] envelope_width;
  } cfg_t;

  typedef struct packed {
    logic clr_wr;     // clearing pass: zero one slice count
    logic capture;    // word accepted: latch cell, read its count
    logic upd;        // write back incremented count
    logic div_start;
    logic walk_rd;    // read count at cursor
    logic walk_add;   // add it and advance cursor
    logic emit;       // load result register, next block
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic last_cell;
    logic div_done;
    logic walk_more;
    logic out_free;
    logic final_block;
  } sts_t;

endpackage
`default_nettype wire

>>> src/acsp_in_if.sv
`default_nettype none
interface acsp_in_if;
  logic valid;
  logic ready;
  logic [9:0] cell_x;
  logic [9:0] cell_y;
  logic signed [7:0] cell_type;
  logic last_cell;

  modport source (output valid, output cell_x, output cell_y, output cell_type,
                  output last_cell, input ready);
  modport sink (input valid, input cell_x, input cell_y, input cell_type,
                input last_cell, output ready);
endinterface
`default_nettype wire

>>> src/acsp_out_if.sv
`default_nettype none
interface acsp_out_if;
  logic valid;
  logic ready;
  logic [5:0] block_index;
  logic [10:0] slice_start;
  logic signed [10:0] slice_end;
  logic [7:0] envelope;
  logic last_block;

  modport source (output valid, output block_index, output slice_start,
                  output slice_end, output envelope, output last_block, input ready);
  modport sink (input valid, input block_index, input slice_start,
                input slice_end, input envelope, input last_block, output ready);
endinterface
`default_nettype wire

>>> src/acsp_div.sv
`default_nettype none
// restoring divider, one quotient bit a cycle
module acsp_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [acsp_pkg::TOTAL_W-1:0] dividend,
  input  wire logic [acsp_pkg::BLK_W-1:0] divisor,
  output logic [acsp_pkg::TOTAL_W-1:0] quotient,
  output logic done
);
  localparam int QW = acsp_pkg::TOTAL_W;
  localparam int DW = acsp_pkg::BLK_W;
  localparam int NW = $clog2(QW);

  logic busy_r;
  logic done_r;
  logic [NW-1:0] cnt_r;
  logic [QW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW:0] trial;
  logic fits;

  assign trial = {rem_r, q_r[QW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NW'(1);
        if (cnt_r == NW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[QW-2:0], fits};
      rem_r <= fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |-> rem_r < divisor)
    else $error("divider remainder not below divisor");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running divide");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divide started while one is running");
endmodule
`default_nettype wire

>>> src/acsp_ctrl.sv
`default_nettype none
module acsp_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire acsp_pkg::sts_t sts,
  output acsp_pkg::cmd_t cmd
);
  typedef enum logic [2:0] {
    ST_CLR, ST_LOAD, ST_UPD, ST_DIVS, ST_DIVW, ST_WALK, ST_ADD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.last_cell ? ST_DIVS : ST_LOAD;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts.div_done) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_more) begin
          cmd.walk_rd = 1'b1;
          state_nxt   = ST_ADD;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.final_block) state_nxt = ST_CLR;
        end
      end
      ST_ADD: begin
        cmd.walk_add = 1'b1;
        state_nxt    = ST_WALK;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  assign in_ready = (state_r == ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else        state_r <= state_nxt;
  end

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while previous count update pending");
  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.final_block |=> state_r == ST_CLR)
    else $error("no clearing pass after final block");
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.walk_more && sts.out_free)
    else $error("block emitted before its range closed");
endmodule
`default_nettype wire

>>> src/acsp_dp.sv
`default_nettype none
module acsp_dp #(
  parameter int MAX_SIDE   = acsp_pkg::DEF_MAX_SIDE,
  parameter int MAX_BLOCKS = acsp_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire acsp_pkg::cfg_t cfg,
  input  wire logic [9:0] cell_x,
  input  wire logic [9:0] cell_y,
  input  wire logic signed [7:0] cell_type,
  input  wire logic last_cell,
  input  wire acsp_pkg::cmd_t cmd,
  output acsp_pkg::sts_t sts,
  acsp_out_if.source out_ch
);
  localparam int AW    = $clog2(MAX_SIDE);
  localparam int CW    = $clog2(MAX_SIDE + 1);
  localparam int CNT_W = acsp_pkg::CNT_W;
  localparam int TW    = acsp_pkg::TOTAL_W;
  localparam int ACW   = acsp_pkg::ACC_W;
  localparam int BW    = acsp_pkg::BLK_W;

  logic [CNT_W-1:0] mem [MAX_SIDE];

  logic [CW-1:0] w_cl, h_cl, nslices;
  logic [BW-1:0] blocks;
  logic [31:0] gw32, gh32, bc32;
  logic hit;
  logic [9:0] s10;
  logic [AW-1:0] in_addr;

  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] slice_r;
  logic hit_r, last_r;
  logic [CNT_W-1:0] rd_r;
  logic [TW-1:0] total_r;
  logic [CW-1:0] cursor_r, start_r;
  logic [ACW-1:0] acc_r;
  logic [BW-1:0] block_r;
  logic [TW-1:0] quota;
  logic div_done;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [CNT_W-1:0] mem_wd;

  logic out_valid_r;
  logic [5:0] o_index_r;
  logic [10:0] o_start_r;
  logic [10:0] o_end_r;
  logic [7:0] o_env_r;
  logic o_last_r;
  logic [31:0] start32, end32;

  // grid and block-count clamps
  assign gw32 = 32'(cfg.grid_width);
  assign gh32 = 32'(cfg.grid_height);
  assign bc32 = 32'(cfg.block_count);
  assign w_cl = (gw32 == 32'd0) ? CW'(1) : (gw32 > 32'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(gw32);
  assign h_cl = (gh32 == 32'd0) ? CW'(1) : (gh32 > 32'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(gh32);
  assign nslices = cfg.slice_axis ? h_cl : w_cl;
  assign blocks = (bc32 == 32'd0) ? BW'(1) :
                  (bc32 > 32'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : cfg.block_count;

  assign hit = (cell_type > 8'sd0) && (32'(cell_x) < 32'(w_cl)) && (32'(cell_y) < 32'(h_cl));
  assign s10 = cfg.slice_axis ? cell_y : cell_x;
  assign in_addr = AW'(32'(s10));

  // slice count store: one write, one registered read a cycle
  assign mem_we = cmd.clr_wr || (cmd.upd && hit_r);
  assign mem_wa = cmd.clr_wr ? clr_cnt_r : slice_r;
  assign mem_wd = cmd.clr_wr ? '0 :
                  (rd_r == acsp_pkg::SLICE_CNT_MAX) ? rd_r : rd_r + CNT_W'(1);
  assign mem_re = cmd.capture || cmd.walk_rd;
  assign mem_ra = cmd.walk_rd ? cursor_r[AW-1:0] : in_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slice_r <= in_addr;
      hit_r   <= hit;
      last_r  <= last_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      total_r   <= '0;
      cursor_r  <= '0;
      start_r   <= '0;
      acc_r     <= '0;
      block_r   <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= (clr_cnt_r == AW'(MAX_SIDE - 1)) ? '0 : clr_cnt_r + AW'(1);
        total_r   <= '0;
        cursor_r  <= '0;
        start_r   <= '0;
        acc_r     <= '0;
        block_r   <= '0;
      end
      if (cmd.upd && hit_r && total_r != acsp_pkg::TOTAL_MAX) total_r <= total_r + TW'(1);
      if (cmd.walk_add) begin
        acc_r    <= acc_r + ACW'(rd_r);
        cursor_r <= cursor_r + CW'(1);
      end
      if (cmd.emit) begin
        block_r <= block_r + BW'(1);
        start_r <= cursor_r;
        acc_r   <= '0;
      end
    end
  end

  acsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (total_r),
    .divisor  (blocks),
    .quotient (quota),
    .done     (div_done)
  );

  // result register
  assign start32 = 32'(start_r);
  assign end32   = 32'(cursor_r) - 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_index_r <= block_r[5:0];
      o_start_r <= start32[10:0];
      o_end_r   <= end32[10:0];
      o_env_r   <= cfg.envelope_width;
      o_last_r  <= sts.final_block;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.block_index = o_index_r;
  assign out_ch.slice_start = o_start_r;
  assign out_ch.slice_end   = $signed(o_end_r);
  assign out_ch.envelope    = o_env_r;
  assign out_ch.last_block  = o_last_r;

  assign sts.clr_done    = (clr_cnt_r == AW'(MAX_SIDE - 1));
  assign sts.last_cell   = last_r;
  assign sts.div_done    = div_done;
  assign sts.walk_more   = (acc_r < ACW'(quota)) && (cursor_r < nslices);
  assign sts.out_free    = !out_valid_r || out_ch.ready;
  assign sts.final_block = ((block_r + BW'(1)) == blocks);

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_rd |-> cursor_r < CW'(MAX_SIDE))
    else $error("slice read beyond store");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r || out_ch.ready)
    else $error("result register overwritten while held");
  a_block_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> block_r < blocks)
    else $error("more blocks emitted than configured");
endmodule
`default_nettype wire

>>> src/active_cell_slice_partitioner.sv
`default_nettype none
// Active-cell slice partitioner. Cells arrive one word at a time; each is accepted with a
// read of its slice count, then a counted cell's incremented count is written back, and no
// new cell is accepted before that step. A cell with type above zero inside the grid counts towards its column
// (slice_axis 0) or row (slice_axis 1). After the word flagged last_cell the block divides
// the active total by block_count (start, then one quotient bit a cycle, then done),
// then walks slices from 0, each read through the count store's registered read and then
// added, closing a block when its count reaches the quota or the slices run out, once
// the result register is free; one result word per block, the final one flagged
// last_block. Then, and after reset, a clearing pass zeroes the count store one slice a
// cycle, during which no cell is accepted. Registers are written on cfg_we with cfg_index
// per the register list and may only change while the block is idle.
module active_cell_slice_partitioner #(
  parameter int MAX_SIDE   = acsp_pkg::DEF_MAX_SIDE,
  parameter int MAX_BLOCKS = acsp_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  acsp_in_if.sink   in_ch,
  acsp_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [acsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [acsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  acsp_pkg::cfg_t cfg_r;
  acsp_pkg::cmd_t cmd;
  acsp_pkg::sts_t sts;
  logic in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slice_axis     <= 1'b0;
      cfg_r.block_count    <= 7'd1;
      cfg_r.grid_width     <= 11'd1024;
      cfg_r.grid_height    <= 11'd1024;
      cfg_r.envelope_width <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        acsp_pkg::CFG_SLICE_AXIS:     cfg_r.slice_axis     <= cfg_data[0];
        acsp_pkg::CFG_BLOCK_COUNT:    cfg_r.block_count    <= cfg_data[6:0];
        acsp_pkg::CFG_GRID_WIDTH:     cfg_r.grid_width     <= cfg_data;
        acsp_pkg::CFG_GRID_HEIGHT:    cfg_r.grid_height    <= cfg_data;
        acsp_pkg::CFG_ENVELOPE_WIDTH: cfg_r.envelope_width <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;

  acsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acsp_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cell_x    (in_ch.cell_x),
    .cell_y    (in_ch.cell_y),
    .cell_type (in_ch.cell_type),
    .last_cell (in_ch.last_cell),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

>>> sim/active_cell_slice_partitioner_tb.sv
module active_cell_slice_partitioner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIDE     = acsp_pkg::DEF_MAX_SIDE;
  localparam int MAX_BLOCKS   = acsp_pkg::DEF_MAX_BLOCKS;
  localparam int CNT_W        = acsp_pkg::CNT_W;
  localparam int TOTAL_W      = acsp_pkg::TOTAL_W;
  localparam int BLK_W        = acsp_pkg::BLK_W;
  localparam int CFG_IDX_W    = acsp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = acsp_pkg::CFG_DATA_W;
  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT     = 16;
  localparam int CLEAR_WAIT   = MAX_SIDE + 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_CELLS = 205;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] cell_type;
    logic       last;
  } cell_t;

  typedef struct packed {
    logic [5:0]  index;
    logic [10:0] first;
    logic [10:0] last_slice;
    logic [7:0]  envelope;
    logic        final_blk;
  } block_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  acsp_in_if  cells_if ();
  acsp_out_if blocks_if ();

  active_cell_slice_partitioner DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cells_if),
    .out_ch   (blocks_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // shadow registers and slice counts
  acsp_pkg::cfg_t regs;
  logic [CNT_W-1:0] slice_count [MAX_SIDE];
  logic [TOTAL_W-1:0] active_sum;
  block_t expected_blocks [$];

  int unsigned errors = 0;
  int unsigned cells_sent = 0;
  int unsigned runs_done = 0;
  int unsigned blocks_checked = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void clear_counts();
    foreach (slice_count[i]) slice_count[i] = '0;
    active_sum = '0;
  endfunction

  function automatic acsp_pkg::cfg_t settings(bit axis, int unsigned blocks, int unsigned w,
                                              int unsigned h, int unsigned env);
    acsp_pkg::cfg_t c;
    c.slice_axis     = axis;
    c.block_count    = BLK_W'(blocks);
    c.grid_width     = CNT_W'(w);
    c.grid_height    = CNT_W'(h);
    c.envelope_width = 8'(env);
    return c;
  endfunction

  function automatic cell_t make_cell(int unsigned x, int unsigned y, int t, bit last);
    cell_t c;
    c.x         = 10'(x);
    c.y         = 10'(y);
    c.cell_type = 8'(t);
    c.last      = last;
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] random_side();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CNT_W'($urandom_range(MAX_SIDE + 1, 2047));
      2: return CNT_W'($urandom_range(17, MAX_SIDE));
      default: return CNT_W'($urandom_range(1, 16));
    endcase
  endfunction

  // count the cell, and on the last one walk the slices into blocks
  function automatic void partition_cell(cell_t c);
    int unsigned w, h, s, nslices, blocks, quota, cursor, acc;
    block_t b;
    w = clamp_to(regs.grid_width, MAX_SIDE);
    h = clamp_to(regs.grid_height, MAX_SIDE);
    if ($signed(c.cell_type) > 0 && c.x < w && c.y < h) begin
      s = regs.slice_axis ? c.y : c.x;
      if (slice_count[s] != acsp_pkg::SLICE_CNT_MAX) slice_count[s]++;
      if (active_sum != acsp_pkg::TOTAL_MAX) active_sum++;
    end
    if (!c.last) return;
    nslices = regs.slice_axis ? h : w;
    blocks  = clamp_to(regs.block_count, MAX_BLOCKS);
    quota   = active_sum / blocks;
    cursor  = 0;
    for (int unsigned k = 0; k < blocks; k++) begin
      b.index = 6'(k);
      b.first = 11'(cursor);
      acc = 0;
      while (acc < quota && cursor < nslices) begin
        acc += slice_count[cursor];
        cursor++;
      end
      // empty block reports start - 1, wrapping to all ones at slice 0
      b.last_slice = 11'(cursor - 1);
      b.envelope   = regs.envelope_width;
      b.final_blk  = (k + 1 == blocks);
      expected_blocks.insert(expected_blocks.size(), b);
    end
    clear_counts();
    runs_done++;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_cell(input cell_t c);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      cells_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cells_if.valid     <= 1'b1;
    cells_if.cell_x    <= c.x;
    cells_if.cell_y    <= c.y;
    cells_if.cell_type <= c.cell_type;
    cells_if.last_cell <= c.last;
    @(posedge clk);
    while (!cells_if.ready) @(posedge clk);
    partition_cell(c);
    cells_sent++;
  endtask

  // drain all blocks, then let the clearing pass finish
  task automatic settle();
    cells_if.valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (CLEAR_WAIT) @(posedge clk);
  endtask

  task automatic apply_config(input acsp_pkg::cfg_t c);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= acsp_pkg::CFG_SLICE_AXIS;
    cfg_data  <= CFG_DATA_W'(c.slice_axis);
    @(posedge clk);
    cfg_index <= acsp_pkg::CFG_BLOCK_COUNT;
    cfg_data  <= CFG_DATA_W'(c.block_count);
    @(posedge clk);
    cfg_index <= acsp_pkg::CFG_GRID_WIDTH;
    cfg_data  <= CFG_DATA_W'(c.grid_width);
    @(posedge clk);
    cfg_index <= acsp_pkg::CFG_GRID_HEIGHT;
    cfg_data  <= CFG_DATA_W'(c.grid_height);
    @(posedge clk);
    cfg_index <= acsp_pkg::CFG_ENVELOPE_WIDTH;
    cfg_data  <= CFG_DATA_W'(c.envelope_width);
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = c;
  endtask

  // reset values, full-range types and coordinates
  task automatic test_defaults();
    send_cell(make_cell(0, 0, 1, 0));
    send_cell(make_cell(1023, 1023, 127, 0));
    send_cell(make_cell(3, 5, 0, 0));
    send_cell(make_cell(3, 5, -128, 0));
    send_cell(make_cell(3, 5, -1, 0));
    send_cell(make_cell(1023, 0, 127, 1));
  endtask

  // quota of zero: every block empty at the cursor
  task automatic test_empty_blocks();
    apply_config(settings(1'b0, 4, 8, 8, 0));
    send_cell(make_cell(2, 2, 1, 0));
    send_cell(make_cell(1, 1, -5, 1));
    send_cell(make_cell(3, 3, 0, 1));
  endtask

  task automatic test_register_clamps();
    apply_config(settings(1'b0, 0, 0, 2047, 255));
    send_cell(make_cell(0, 1000, 1, 0));
    send_cell(make_cell(1, 0, 1, 1));
    apply_config(settings(1'b1, 127, 2047, 0, 0));
    send_cell(make_cell(1023, 0, 1, 0));
    send_cell(make_cell(0, 1, 1, 1));
  endtask

  // off-grid cells ignored, last cell off-grid, tail slices left over
  task automatic test_outside_grid();
    apply_config(settings(1'b0, 3, 5, 3, 17));
    send_cell(make_cell(4, 2, 1, 0));
    send_cell(make_cell(5, 0, 1, 0));
    send_cell(make_cell(0, 3, 1, 0));
    send_cell(make_cell(1, 2, 1, 0));
    send_cell(make_cell(2, 0, 3, 0));
    send_cell(make_cell(0, 0, 1, 0));
    send_cell(make_cell(0, 0, 1, 0));
    send_cell(make_cell(6, 1, 1, 1));
  endtask

  task automatic test_row_slices();
    apply_config(settings(1'b1, 2, 4, 6, 200));
    send_cell(make_cell(0, 5, 1, 0));
    send_cell(make_cell(3, 5, 1, 0));
    send_cell(make_cell(1, 0, 1, 0));
    send_cell(make_cell(2, 2, 1, 1));
  endtask

  task automatic test_random();
    int unsigned run, sent, burst, w, h;
    acsp_pkg::cfg_t c;
    cell_t item;
    run  = 0;
    sent = 0;
    while (sent < RANDOM_CELLS) begin
      // a long stretch with both sides streaming
      calm = (sent >= 60 && sent < 130);
      if (run == 0 || $urandom_range(0, 1) == 1) begin
        c.slice_axis = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0: c.block_count = 7'd0;
          1: c.block_count = 7'd64;
          2: c.block_count = 7'($urandom_range(65, 127));
          default: c.block_count = 7'($urandom_range(1, 8));
        endcase
        c.grid_width     = random_side();
        c.grid_height    = random_side();
        c.envelope_width = 8'($urandom());
        apply_config(c);
      end
      w = clamp_to(regs.grid_width, MAX_SIDE);
      h = clamp_to(regs.grid_height, MAX_SIDE);
      // many blocks need many cells for a non-zero quota
      burst = (regs.block_count > 8) ? $urandom_range(64, 96) : $urandom_range(1, 20);
      if (burst > RANDOM_CELLS - sent) burst = RANDOM_CELLS - sent;
      for (int unsigned k = 1; k <= burst; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          item = make_cell($urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 255), 1'b0);
        end else begin
          item = make_cell($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                           $urandom_range(1, 127), 1'b0);
        end
        item.last = (k == burst);
        send_cell(item);
        sent++;
      end
      run++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) blocks_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  always @(posedge clk) begin : result_check
    block_t want;
    if (rst_n && blocks_if.valid && blocks_if.ready) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result word for block %0d", blocks_if.block_index);
        errors++;
      end else begin
        want = expected_blocks.pop_front();
        check_field("block_index", want.index, blocks_if.block_index);
        check_field("slice_start", want.first, blocks_if.slice_start);
        check_field("slice_end", want.last_slice, $unsigned(blocks_if.slice_end));
        check_field("envelope", want.envelope, blocks_if.envelope);
        check_field("last_block", want.final_blk, blocks_if.last_block);
        blocks_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= acsp_pkg::CFG_SLICE_AXIS;
    cfg_data           <= '0;
    cells_if.valid     <= 1'b0;
    cells_if.cell_x    <= '0;
    cells_if.cell_y    <= '0;
    cells_if.cell_type <= '0;
    cells_if.last_cell <= 1'b0;
    regs = settings(1'b0, 1, MAX_SIDE, MAX_SIDE, 1);
    clear_counts();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_empty_blocks();
    test_register_clamps();
    test_outside_grid();
    test_row_slices();
    test_random();
    settle();

    $display("%0d cells sent over %0d partition runs, %0d block words checked",
             cells_sent, runs_done, blocks_checked);
    $display("Both axes, clamped registers, off-grid cells, empty blocks and random grids");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> active_cell_slice_partitioner.f
src/acsp_pkg.sv
src/acsp_in_if.sv
src/acsp_out_if.sv
src/acsp_div.sv
src/acsp_ctrl.sv
src/acsp_dp.sv
src/active_cell_slice_partitioner.sv
sim/active_cell_slice_partitioner_tb.sv
